FILE: sv/hmm_pkg.sv
// Package for the histogram matching map: constants, operation codes,
// item and command types and the back-end state type. No dependencies.
package hmm_pkg;

    localparam int COUNT_BITS = 22;
    localparam int BIN_BITS   = 8;
    localparam int NBINS      = 1 << BIN_BITS;
    localparam int CUM_BITS   = COUNT_BITS + BIN_BITS;
    localparam int GAIN_BITS  = 12;
    localparam int PROD_BITS  = BIN_BITS + GAIN_BITS;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    localparam logic [GAIN_BITS-1:0]  GAIN_RESET = GAIN_BITS'(256);
    localparam logic [BIN_BITS-1:0]   MAX_BIN    = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

    localparam logic [2:0] OP_SOURCE = 3'd0;
    localparam logic [2:0] OP_TARGET = 3'd1;
    localparam logic [2:0] OP_BUILD  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]          operation;
        logic [BIN_BITS-1:0] pixel_value;
        logic [BIN_BITS-1:0] bin_index;
    } t_in_item;

    typedef struct packed {
        logic [BIN_BITS-1:0] mapped_bin;
        logic                mapped_valid;
        logic                map_built;
        logic                count_overflow;
    } t_out_item;

    typedef struct packed {
        logic [2:0]          op;
        logic [BIN_BITS-1:0] bin;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_LD_RD,
        S_LD_WR,
        S_CDF_RD,
        S_CDF_WR,
        S_T_RD,
        S_T_WAIT,
        S_J_RD,
        S_J_WAIT,
        S_RD_RD,
        S_RD_OUT
    } t_bstate;

endpackage

FILE: sv/hmm_front.sv
// Front end: accepts items, scales target pixels by the gain and turns each
// item with a known operation into a command for the queue. Depends on hmm_pkg.
module hmm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  hmm_pkg::t_in_item             i_in_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hmm_pkg::GAIN_BITS-1:0] i_cfg_data,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output hmm_pkg::t_cmd                 o_q_cmd
);
    import hmm_pkg::*;

    logic [GAIN_BITS-1:0] r_gain;
    logic [PROD_BITS-1:0] prod;
    logic [GAIN_BITS-1:0] scaled;
    logic                 known_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign prod        = PROD_BITS'(i_in_item.pixel_value) * PROD_BITS'(r_gain);
    assign scaled      = prod[PROD_BITS-1:BIN_BITS];
    assign known_op    = (i_in_item.operation <= OP_CLEAR);
    assign o_q_push    = i_in_valid && !i_q_full && known_op;

    always_comb begin
        o_q_cmd.op  = i_in_item.operation;
        o_q_cmd.bin = '0;
        case (i_in_item.operation)
            OP_SOURCE: o_q_cmd.bin = i_in_item.pixel_value;
            OP_TARGET: o_q_cmd.bin = (scaled > GAIN_BITS'(MAX_BIN)) ? MAX_BIN
                                                                    : scaled[BIN_BITS-1:0];
            OP_READ:   o_q_cmd.bin = i_in_item.bin_index;
            default:   o_q_cmd.bin = '0;
        endcase
    end

endmodule

FILE: sv/hmm_queue.sv
// Short command queue between the front end and the back end.
// Depends on hmm_pkg.
module hmm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hmm_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output hmm_pkg::t_cmd o_cmd
);
    import hmm_pkg::*;

    t_cmd                r_slot [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wp, r_rp;
    logic [Q_PTR_BITS:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Q_PTR_BITS+1)'(i_push) - (Q_PTR_BITS+1)'(i_pop);
        end
    end

endmodule

FILE: sv/hmm_back.sv
// Back end: histogram memories, the build sequencer, the map memory and the
// output register. Depends on hmm_pkg.
module hmm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  hmm_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hmm_pkg::t_out_item o_out_item
);
    import hmm_pkg::*;

    t_bstate r_state, n_state;

    t_cmd                r_cmd, n_cmd;
    logic [BIN_BITS-1:0] r_i, n_i, r_j, n_j;
    logic [CUM_BITS-1:0] r_v, n_v, r_prev, n_prev, r_ssum, n_ssum, r_tsum, n_tsum;
    logic                r_up, n_up, r_first, n_first;
    logic                r_sany, n_sany, r_tany, n_tany;
    logic [BIN_BITS-1:0] r_slo, n_slo, r_shi, n_shi, r_tlo, n_tlo, r_thi, n_thi;
    logic                r_built, n_built, r_ovf, n_ovf;
    logic                r_oval, n_oval;
    t_out_item           r_oitem, n_oitem;

    logic [COUNT_BITS-1:0] m_scnt [NBINS];
    logic [COUNT_BITS-1:0] m_tcnt [NBINS];
    logic [CUM_BITS-1:0]   m_scdf [NBINS];
    logic [CUM_BITS-1:0]   m_tcdf [NBINS];
    logic [BIN_BITS:0]     m_map  [NBINS];

    logic [COUNT_BITS-1:0] r_scnt_rd, r_tcnt_rd;
    logic [CUM_BITS-1:0]   r_scdf_rd, r_tcdf_rd;
    logic [BIN_BITS:0]     r_map_rd;

    logic [BIN_BITS-1:0]   cnt_ra, cnt_wa, map_wa;
    logic                  scnt_we, tcnt_we, cdf_we, map_we;
    logic [COUNT_BITS-1:0] cnt_wd;
    logic [CUM_BITS-1:0]   scdf_wd, tcdf_wd;
    logic [BIN_BITS:0]     map_wd;

    logic [COUNT_BITS-1:0] cur_cnt, sc, tc;
    logic                  out_free, up_dir, done;
    logic [BIN_BITS-1:0]   match;
    logic                  ok;

    assign out_free = !r_oval || !i_out_stall;
    assign cur_cnt  = (r_cmd.op == OP_SOURCE) ? r_scnt_rd : r_tcnt_rd;
    assign sc       = r_scnt_rd;
    assign tc       = r_tcnt_rd;
    assign up_dir   = r_first ? (r_scdf_rd <= r_v) : r_up;

    always_comb begin
        done  = 1'b0;
        match = r_j;
        if (r_scdf_rd == r_v) begin
            done = 1'b1;
        end else if (up_dir) begin
            if (r_scdf_rd > r_v) begin
                done  = 1'b1;
                match = ((r_scdf_rd - r_v) <= (r_v - r_prev)) ? r_j : r_j - 1'b1;
            end else if (r_j == MAX_BIN) begin
                done = 1'b1;
            end
        end else begin
            if (r_scdf_rd < r_v) begin
                done  = 1'b1;
                match = ((r_v - r_scdf_rd) <= (r_prev - r_v)) ? r_j : r_j + 1'b1;
            end else if (r_j == '0) begin
                done = 1'b1;
            end
        end
    end

    assign ok = r_sany && r_tany && (r_i >= r_tlo) && (r_i <= r_thi) &&
                (match >= r_slo) && (match <= r_shi);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    case (i_q_cmd.op)
                        OP_SOURCE, OP_TARGET: n_state = S_LD_RD;
                        OP_BUILD:             n_state = S_CDF_RD;
                        OP_READ:              n_state = S_RD_RD;
                        OP_CLEAR:             n_state = S_CLR;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR:    n_state = (r_i == MAX_BIN) ? S_IDLE : S_CLR;
            S_LD_RD:  n_state = S_LD_WR;
            S_LD_WR:  n_state = S_IDLE;
            S_CDF_RD: n_state = S_CDF_WR;
            S_CDF_WR: n_state = (r_i == MAX_BIN) ? S_T_RD : S_CDF_RD;
            S_T_RD:   n_state = S_T_WAIT;
            S_T_WAIT: n_state = S_J_RD;
            S_J_RD:   n_state = S_J_WAIT;
            S_J_WAIT: begin
                if (!done) begin
                    n_state = S_J_RD;
                end else if (r_i == MAX_BIN) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_T_RD;
                end
            end
            S_RD_RD:  n_state = S_RD_OUT;
            S_RD_OUT: n_state = out_free ? S_IDLE : S_RD_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd   = r_cmd;
        n_i     = r_i;
        n_j     = r_j;
        n_v     = r_v;
        n_prev  = r_prev;
        n_ssum  = r_ssum;
        n_tsum  = r_tsum;
        n_up    = r_up;
        n_first = r_first;
        n_sany  = r_sany;
        n_tany  = r_tany;
        n_slo   = r_slo;
        n_shi   = r_shi;
        n_tlo   = r_tlo;
        n_thi   = r_thi;
        n_built = r_built;
        n_ovf   = r_ovf;
        n_oval  = r_oval && i_out_stall;
        n_oitem = r_oitem;
        o_q_pop = 1'b0;
        cnt_ra  = r_cmd.bin;
        cnt_wa  = r_cmd.bin;
        scnt_we = 1'b0;
        tcnt_we = 1'b0;
        cnt_wd  = cur_cnt + 1'b1;
        cdf_we  = 1'b0;
        scdf_wd = r_ssum + CUM_BITS'(sc);
        tcdf_wd = r_tsum + CUM_BITS'(tc);
        map_we  = 1'b0;
        map_wa  = r_i;
        map_wd  = ok ? {1'b1, match} : '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_i     = '0;
                    n_j     = '0;
                    n_ssum  = '0;
                    n_tsum  = '0;
                    n_sany  = 1'b0;
                    n_tany  = 1'b0;
                    if (i_q_cmd.op == OP_BUILD) begin
                        n_slo = '0;
                        n_shi = '0;
                        n_tlo = '0;
                        n_thi = '0;
                    end
                    if (i_q_cmd.op == OP_CLEAR) begin
                        n_slo   = '0;
                        n_shi   = '0;
                        n_tlo   = '0;
                        n_thi   = '0;
                        n_built = 1'b0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            S_CLR: begin
                cnt_wa  = r_i;
                cnt_wd  = '0;
                scnt_we = 1'b1;
                tcnt_we = 1'b1;
                map_we  = 1'b1;
                map_wd  = '0;
                n_i     = r_i + 1'b1;
            end
            S_LD_RD: begin
                cnt_ra = r_cmd.bin;
            end
            S_LD_WR: begin
                n_built = 1'b0;
                if (cur_cnt == COUNT_MAX) begin
                    n_ovf = 1'b1;
                end else if (r_cmd.op == OP_SOURCE) begin
                    scnt_we = 1'b1;
                end else begin
                    tcnt_we = 1'b1;
                end
            end
            S_CDF_RD: begin
                cnt_ra = r_i;
            end
            S_CDF_WR: begin
                cdf_we = 1'b1;
                n_ssum = scdf_wd;
                n_tsum = tcdf_wd;
                if (sc != '0) begin
                    if (!r_sany) begin
                        n_slo = r_i;
                    end
                    n_shi  = r_i;
                    n_sany = 1'b1;
                end
                if (tc != '0) begin
                    if (!r_tany) begin
                        n_tlo = r_i;
                    end
                    n_thi  = r_i;
                    n_tany = 1'b1;
                end
                n_i = r_i + 1'b1;
                n_j = '0;
            end
            S_T_RD: begin
            end
            S_T_WAIT: begin
                n_v     = r_tcdf_rd;
                n_first = 1'b1;
            end
            S_J_RD: begin
            end
            S_J_WAIT: begin
                n_first = 1'b0;
                n_up    = up_dir;
                if (done) begin
                    map_we = 1'b1;
                    n_j    = match;
                    n_i    = r_i + 1'b1;
                    if (r_i == MAX_BIN) begin
                        n_built = 1'b1;
                    end
                end else begin
                    n_prev = r_scdf_rd;
                    n_j    = up_dir ? r_j + 1'b1 : r_j - 1'b1;
                end
            end
            S_RD_RD: begin
            end
            S_RD_OUT: begin
                if (out_free) begin
                    n_oval                 = 1'b1;
                    n_oitem.mapped_bin     = r_map_rd[BIN_BITS-1:0];
                    n_oitem.mapped_valid   = r_map_rd[BIN_BITS];
                    n_oitem.map_built      = r_built;
                    n_oitem.count_overflow = r_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (scnt_we) begin
            m_scnt[cnt_wa] <= cnt_wd;
        end
        if (tcnt_we) begin
            m_tcnt[cnt_wa] <= cnt_wd;
        end
        r_scnt_rd <= m_scnt[cnt_ra];
        r_tcnt_rd <= m_tcnt[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cdf_we) begin
            m_scdf[r_i] <= scdf_wd;
            m_tcdf[r_i] <= tcdf_wd;
        end
        r_scdf_rd <= m_scdf[r_j];
        r_tcdf_rd <= m_tcdf[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            m_map[map_wa] <= map_wd;
        end
        r_map_rd <= m_map[r_cmd.bin];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_i     <= '0;
            r_sany  <= 1'b0;
            r_tany  <= 1'b0;
            r_slo   <= '0;
            r_shi   <= '0;
            r_tlo   <= '0;
            r_thi   <= '0;
            r_built <= 1'b0;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
            r_first <= 1'b0;
            r_up    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_sany  <= n_sany;
            r_tany  <= n_tany;
            r_slo   <= n_slo;
            r_shi   <= n_shi;
            r_tlo   <= n_tlo;
            r_thi   <= n_thi;
            r_built <= n_built;
            r_ovf   <= n_ovf;
            r_oval  <= n_oval;
            r_first <= n_first;
            r_up    <= n_up;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_j     <= n_j;
        r_v     <= n_v;
        r_prev  <= n_prev;
        r_ssum  <= n_ssum;
        r_tsum  <= n_tsum;
        r_oitem <= n_oitem;
    end

    assign o_out_valid = r_oval;
    assign o_out_item  = r_oitem;

endmodule

FILE: sv/histogram_matching_map.sv
// Top level of the histogram matching map: front end, command queue and
// back end. Depends on hmm_pkg, hmm_front, hmm_queue and hmm_back.
//
// Items are taken into a four-deep queue at one item per cycle while it has
// room; the back end then carries out each source or target load as the
// dequeue and a read-modify-write of the count memory, each read as the
// dequeue, a map memory read and the output, held while the output is
// stalled, and a clear by zeroing the count and map memories one bin per
// cycle. The same pass runs after reset before the first item is carried out.
// A build forms the cumulative sums one bin at a time (S_CDF_RD, S_CDF_WR),
// then for every target bin reads its cumulative sum and walks the source
// sums towards the nearest value, with S_J_RD and S_J_WAIT per source bin.
// A result waits in the output register while the queue goes on taking items.
module histogram_matching_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  hmm_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output hmm_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hmm_pkg::GAIN_BITS-1:0] i_cfg_data
);
    import hmm_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_in, q_out;

    hmm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in)
    );

    hmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out)
    );

    hmm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_cmd     (q_out),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for histogram_matching_map: directed and random source,
// target, build, read, clear and unknown-operation items, gain changes and random
// idling on both sides. Depends on hmm_pkg and the histogram_matching_map RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hmm_pkg::*;

    class map_scoreboard;
        logic [GAIN_BITS-1:0]  gain;
        logic [COUNT_BITS-1:0] src_hist [NBINS];
        logic [COUNT_BITS-1:0] tgt_hist [NBINS];
        longint unsigned       src_cum [NBINS];
        longint unsigned       tgt_cum [NBINS];
        logic [BIN_BITS-1:0]   map_bin [NBINS];
        logic                  map_ok [NBINS];
        logic [BIN_BITS-1:0]   src_lo, src_hi, tgt_lo, tgt_hi;
        logic                  built, overflow;
        t_out_item             pending_reads [$];
        int                    mismatches;

        function new();
            gain = GAIN_RESET;
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            for (int i = 0; i < NBINS; i++) begin
                src_hist[i] = '0;
                tgt_hist[i] = '0;
                map_bin[i] = '0;
                map_ok[i] = 1'b0;
            end
            src_lo = '0; src_hi = '0; tgt_lo = '0; tgt_hi = '0;
            built = 1'b0;
            overflow = 1'b0;
        endfunction

        function void bump(bit to_source, logic [BIN_BITS-1:0] bin);
            logic [COUNT_BITS-1:0] c;
            c = to_source ? src_hist[bin] : tgt_hist[bin];
            if (c == COUNT_MAX) overflow = 1'b1;
            else if (to_source) src_hist[bin] = c + 1'b1;
            else tgt_hist[bin] = c + 1'b1;
            built = 1'b0;
        endfunction

        function bit accumulate(bit of_source, output logic [BIN_BITS-1:0] lo,
                                output logic [BIN_BITS-1:0] hi);
            longint unsigned sum;
            bit any;
            sum = 0; any = 0; lo = '0; hi = '0;
            for (int i = 0; i < NBINS; i++) begin
                longint unsigned c;
                c = of_source ? src_hist[i] : tgt_hist[i];
                if (c > 0) begin
                    if (!any) lo = BIN_BITS'(i);
                    hi = BIN_BITS'(i);
                    any = 1;
                end
                sum += c;
                if (of_source) src_cum[i] = sum;
                else tgt_cum[i] = sum;
            end
            return any;
        endfunction

        function int closest_source_bin(longint unsigned v, int j);
            if (src_cum[j] <= v) begin
                for (; j < NBINS; j++) begin
                    if (src_cum[j] == v) return j;
                    if (src_cum[j] > v)
                        return (src_cum[j] - v <= v - src_cum[j-1]) ? j : j - 1;
                end
                return NBINS - 1;
            end
            forever begin
                if (src_cum[j] == v) return j;
                if (src_cum[j] < v)
                    return (v - src_cum[j] <= src_cum[j+1] - v) ? j : j + 1;
                if (j == 0) return 0;
                j--;
            end
        endfunction

        function void build_map();
            bit s_any, t_any, ok;
            int j;
            s_any = accumulate(1, src_lo, src_hi);
            t_any = accumulate(0, tgt_lo, tgt_hi);
            j = 0;
            for (int i = 0; i < NBINS; i++) begin
                j = closest_source_bin(tgt_cum[i], j);
                ok = s_any && t_any && i >= tgt_lo && i <= tgt_hi &&
                     j >= src_lo && j <= src_hi;
                map_bin[i] = ok ? j[BIN_BITS-1:0] : '0;
                map_ok[i] = ok;
            end
            built = 1'b1;
        endfunction

        function void note_item(t_in_item it);
            logic [PROD_BITS-1:0] prod;
            t_out_item r;
            case (it.operation)
                OP_SOURCE: bump(1, it.pixel_value);
                OP_TARGET: begin
                    prod = (PROD_BITS'(it.pixel_value) * PROD_BITS'(gain)) >> 8;
                    bump(0, (prod > MAX_BIN) ? MAX_BIN : prod[BIN_BITS-1:0]);
                end
                OP_BUILD: build_map();
                OP_READ: begin
                    r.mapped_bin = map_bin[it.bin_index];
                    r.mapped_valid = map_ok[it.bin_index];
                    r.map_built = built;
                    r.count_overflow = overflow;
                    pending_reads.insert(pending_reads.size(), r);
                end
                OP_CLEAR: clear_state();
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending_reads.pop_front();
            if (got.mapped_bin !== want.mapped_bin || got.mapped_valid !== want.mapped_valid ||
                got.map_built !== want.map_built ||
                got.count_overflow !== want.count_overflow) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic                 i_clk, i_rst_n;
    logic                 i_in_valid, o_in_stall;
    t_in_item             i_in_item;
    logic                 o_out_valid, i_out_stall;
    t_out_item            o_out_item;
    logic                 i_cfg_valid, o_cfg_ready;
    logic [GAIN_BITS-1:0] i_cfg_data;
    map_scoreboard        sb;
    bit                   hold_off_req;

    histogram_matching_map uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_item);

    initial begin
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            int n;
            if (hold_off_req) begin
                hold_off_req = 0;
                i_out_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
            end
            n = idle_len();
            i_out_stall <= (n > 0);
            repeat (n > 0 ? n : $urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    task automatic send(logic [2:0] op, logic [7:0] pix, logic [7:0] bin);
        t_in_item it;
        int n;
        it.operation = op;
        it.pixel_value = pix;
        it.bin_index = bin;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(it);
        n = idle_len();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_reads.size() != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    task automatic set_gain(logic [GAIN_BITS-1:0] g);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= g;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.gain = g;
    endtask

    task automatic random_sequence();
        int n, lo, hi;
        lo = $urandom_range(0, 255);
        hi = $urandom_range(lo, 255);
        if ($urandom_range(0, 3) == 0) begin lo = 0; hi = 255; end
        n = $urandom_range(4, 40);
        repeat (n) begin
            if ($urandom_range(0, 19) == 0)
                send(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom));
            else
                send($urandom_range(0, 1) ? OP_SOURCE : OP_TARGET,
                     8'($urandom_range(lo, hi)), 8'($urandom));
        end
        if ($urandom_range(0, 9) != 0) send(OP_BUILD, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(2, 12)) send(OP_READ, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 7) == 0) send(OP_CLEAR, 8'($urandom), 8'($urandom));
    endtask

    initial begin
        logic [GAIN_BITS-1:0] gains [4];
        int sent;
        sb = new();
        hold_off_req = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(OP_READ, 8'h00, 8'hff);
        send(OP_BUILD, 8'h00, 8'h00);
        send(OP_READ, 8'hff, 8'h00);
        send(OP_SOURCE, 8'h00, 8'h00);
        send(OP_SOURCE, 8'hff, 8'h00);
        send(OP_SOURCE, 8'h80, 8'h00);
        send(OP_TARGET, 8'h00, 8'h00);
        send(OP_TARGET, 8'hff, 8'h00);
        send(OP_TARGET, 8'h55, 8'h00);
        send(OP_BUILD, 8'h00, 8'h00);
        send(OP_READ, 8'h00, 8'h00);
        send(OP_READ, 8'h00, 8'hff);
        send(OP_READ, 8'h00, 8'h55);
        send(3'd5, 8'h12, 8'h34);
        send(3'd6, 8'hff, 8'hff);
        send(3'd7, 8'h00, 8'h00);
        send(OP_SOURCE, 8'h10, 8'h00);
        send(OP_READ, 8'h00, 8'h10);
        send(OP_CLEAR, 8'h00, 8'h00);
        send(OP_READ, 8'h00, 8'hff);
        send(OP_TARGET, 8'h20, 8'h00);
        send(OP_BUILD, 8'h00, 8'h00);
        send(OP_READ, 8'h00, 8'h20);

        gains[0] = 12'hfff;
        gains[1] = 12'h000;
        gains[2] = 12'($urandom_range(64, 1024));
        gains[3] = GAIN_RESET;
        for (int p = 0; p < 4; p++) begin
            set_gain(gains[p]);
            sent = 0;
            if (p == 1) begin
                hold_off_req = 1;
                repeat (40) send(OP_READ, 8'($urandom), 8'($urandom));
            end
            while (sent < 330) begin
                random_sequence();
                sent += 30;
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.pending_reads.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
